// File: sv/flow_cache_timeout_exporter_core_defines.svh
// Assertion macros shared by the flow cache RTL.
// No dependencies; included by files that carry assertions.
`ifndef FLOW_CACHE_TIMEOUT_EXPORTER_CORE_DEFINES_SVH
`define FLOW_CACHE_TIMEOUT_EXPORTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define FC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FC_ASSERT(label, clk, rst_n, prop)
`define FC_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: sv/fcte_pkg.sv
// Shared types and constants for the flow cache timeout exporter.
// No dependencies.
package fcte_pkg;

    localparam int CACHE_ENTRIES_DEF = 32;

    localparam logic [1:0] REG_ACTIVE   = 2'd0;
    localparam logic [1:0] REG_INACTIVE = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic ACTION_PACKET = 1'b0;
    localparam logic ACTION_FLUSH  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [5:0]  dscp;
        logic [15:0] ip_length;
        logic [7:0]  tcp_flags;
        logic [31:0] packet_time;
    } in_word_t;

    typedef struct packed {
        logic [31:0] out_src_addr;
        logic [31:0] out_dst_addr;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [7:0]  out_protocol;
        logic [5:0]  out_dscp;
        logic [31:0] out_packets;
        logic [31:0] out_octets;
        logic [31:0] out_first_time;
        logic [31:0] out_last_time;
        logic [7:0]  out_tcp_flags;
        logic        last_of_run;
    } out_word_t;

    // One stored flow, one memory word.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
        logic [13:0] proto_dscp;
        logic [31:0] packets;
        logic [31:0] octets;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [7:0]  flags;
    } flow_t;

endpackage

// File: sv/flow_cache_timeout_exporter_core.sv
// Top level of the flow cache timeout exporter; holds the sequencer and config.
// Depends on fcte_pkg, fcte_flow_mem and the assertion macro header.
//
// One item at a time: busy is high from the cycle after start is taken until
// the last export is driven. A packet with ICMP, TCP or UDP protocol reads each
// stored flow in order, one per cycle through the registered read port, and
// writes survivors back compacted at a write pointer; other packets go straight
// to the eviction check. After the walk come append, eviction check and the
// closing state. A capacity eviction exports the oldest flow and moves the
// rest down by one. A flush exports every stored flow and empties the cache.
// Exports appear on result for one cycle with result_valid; the receiver cannot
// stall, and last_of_run marks the final export of an item.
`include "flow_cache_timeout_exporter_core_defines.svh"
module flow_cache_timeout_exporter_core #(
    parameter int CACHE_ENTRIES = fcte_pkg::CACHE_ENTRIES_DEF,
    localparam int AW = $clog2(CACHE_ENTRIES),
    localparam int CW = $clog2(CACHE_ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fcte_pkg::in_word_t   item,
    output logic                 result_valid,
    output fcte_pkg::out_word_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_APPND = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] act_to_reg, inact_to_reg;
    logic [5:0]  cap_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;   // next address to read
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;   // compaction write pointer
    logic          pend_reg, pend_next;       // a read is in flight
    logic          found_reg, found_next;
    logic          flush_reg;
    fcte_pkg::in_word_t item_reg;
    logic [31:0]   ports_reg;
    logic [13:0]   pd_reg;
    logic [7:0]    fl_reg;
    fcte_pkg::flow_t held_reg, held_next;     // last export, shown when the next one arrives or at the end
    logic          held_v_reg, held_v_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    fcte_pkg::flow_t wr_data;
    logic [AW-1:0]   rd_addr;
    fcte_pkg::flow_t rd_data;

    fcte_flow_mem #(.DEPTH(CACHE_ENTRIES)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_to_reg   <= 32'd60;
            inact_to_reg <= 32'd10;
            cap_reg      <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fcte_pkg::REG_ACTIVE:   act_to_reg   <= cfg_data;
                fcte_pkg::REG_INACTIVE: inact_to_reg <= cfg_data;
                fcte_pkg::REG_CAPACITY: cap_reg      <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Capture the item and its derived key.
    wire [7:0] in_proto = item.protocol;
    wire in_valid_proto = (in_proto == fcte_pkg::PROTO_ICMP) ||
                          (in_proto == fcte_pkg::PROTO_TCP) ||
                          (in_proto == fcte_pkg::PROTO_UDP);
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg  <= item;
            flush_reg <= (item.action == fcte_pkg::ACTION_FLUSH);
            ports_reg <= (in_proto == fcte_pkg::PROTO_ICMP) ? 32'd0 :
                         {item.src_port, item.dst_port};
            pd_reg    <= {in_proto, item.dscp};
            fl_reg    <= (in_proto == fcte_pkg::PROTO_TCP) ? item.tcp_flags : 8'd0;
        end
    end

    // Effective capacity, clamped to the depth.
    logic [CW:0] cap_eff;
    always_comb
    begin
        if ({1'b0, cap_reg} > 7'(CACHE_ENTRIES) && CACHE_ENTRIES < 64)
            cap_eff = (CW+1)'(CACHE_ENTRIES);
        else
            cap_eff = (CW+1)'(cap_reg);
    end

    // Per-entry checks on the word just read.
    logic [31:0] act_t, idle_t;
    logic        expired, matched;
    fcte_pkg::flow_t upd;
    assign act_t   = rd_data.last_time - rd_data.first_time;
    assign idle_t  = item_reg.packet_time - rd_data.last_time;
    assign expired = (act_t >= act_to_reg) || (idle_t >= inact_to_reg);
    assign matched = (rd_data.src_addr == item_reg.src_addr) &&
                     (rd_data.dst_addr == item_reg.dst_addr) &&
                     (rd_data.ports == ports_reg) && (rd_data.proto_dscp == pd_reg);
    always_comb
    begin
        upd = rd_data;
        if (matched)
        begin
            upd.packets   = rd_data.packets + 32'd1;
            upd.octets    = rd_data.octets + {16'd0, item_reg.ip_length};
            upd.last_time = item_reg.packet_time;
            upd.flags     = rd_data.flags | fl_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = 1'b0;
        found_next  = found_reg;
        held_next   = held_reg;
        held_v_next = held_v_reg;
        wr_en       = 1'b0;
        wr_addr     = wr_ptr_reg[AW-1:0];
        wr_data     = upd;
        rd_addr     = rd_idx_reg[AW-1:0];
        result_valid = 1'b0;
        result       = '0;
        // Pending export goes out when a new one arrives or at the end.
        unique case (state_reg)
            ST_IDLE:
            begin
                held_v_next = 1'b0;
                if (start)
                begin
                    rd_idx_next = '0;
                    wr_ptr_next = '0;
                    found_next  = 1'b0;
                    if (item.action == fcte_pkg::ACTION_FLUSH || in_valid_proto)
                        state_next = ST_WALK;
                    else
                        state_next = ST_EVICT;
                end
            end
            ST_WALK:
            begin
                // Issue next read.
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                // Process the read that returned.
                if (pend_reg)
                begin
                    if (flush_reg || expired)
                    begin
                        if (held_v_reg)
                        begin
                            result_valid = 1'b1;
                        end
                        held_next   = rd_data;
                        held_v_next = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                        if (matched)
                            found_next = 1'b1;
                    end
                end
                // All words processed; leave the walk.
                if (!pend_reg && rd_idx_reg >= count_reg)
                begin
                    if (flush_reg)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        count_next = wr_ptr_reg;
                        state_next = ST_APPND;
                    end
                end
            end
            ST_APPND:
            begin
                if (!found_reg && count_reg < CW'(CACHE_ENTRIES))
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                    wr_data.src_addr   = item_reg.src_addr;
                    wr_data.dst_addr   = item_reg.dst_addr;
                    wr_data.ports      = ports_reg;
                    wr_data.proto_dscp = pd_reg;
                    wr_data.packets    = 32'd1;
                    wr_data.octets     = {16'd0, item_reg.ip_length};
                    wr_data.first_time = item_reg.packet_time;
                    wr_data.last_time  = item_reg.packet_time;
                    wr_data.flags      = fl_reg;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                // Read the oldest flow; it is exported if capacity is reached.
                rd_addr = '0;
                if (count_reg != '0 && {1'b0, count_reg} >= cap_eff)
                begin
                    rd_idx_next = CW'(1);
                    pend_next   = 1'b1;
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                // Move entry rd_idx-2 <- rd_idx-1; first returned word is the victim.
                if (pend_reg)
                begin
                    if (rd_idx_reg == CW'(1))
                    begin
                        if (held_v_reg)
                            result_valid = 1'b1;
                        held_next   = rd_data;
                        held_v_next = 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(rd_idx_reg - 2'd2);
                        wr_data = rd_data;
                    end
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_addr     = rd_idx_reg[AW-1:0];
                        rd_idx_next = rd_idx_reg + 1'b1;
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (held_v_reg)
                begin
                    result_valid = 1'b1;
                end
                held_v_next = 1'b0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (result_valid)
        begin
            result.out_src_addr   = held_reg.src_addr;
            result.out_dst_addr   = held_reg.dst_addr;
            result.out_src_port   = held_reg.ports[31:16];
            result.out_dst_port   = held_reg.ports[15:0];
            result.out_protocol   = held_reg.proto_dscp[13:6];
            result.out_dscp       = held_reg.proto_dscp[5:0];
            result.out_packets    = held_reg.packets;
            result.out_octets     = held_reg.octets;
            result.out_first_time = held_reg.first_time;
            result.out_last_time  = held_reg.last_time;
            result.out_tcp_flags  = held_reg.flags;
            result.last_of_run    = (state_reg == ST_DONE);
        end
    end

    // The shift reads entry rd_idx and writes it one lower; the read address
    // in ST_SHIFT is set above, the write lags the read through the registered read port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            wr_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            held_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            wr_ptr_reg <= wr_ptr_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            held_v_reg <= held_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    `FC_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(CACHE_ENTRIES))
    `FC_ASSERT(a_idle_no_result, clk, rst_n, (state_reg == ST_IDLE) |-> !result_valid)
    `FC_ASSERT(a_wr_behind_rd, clk, rst_n, (state_reg == ST_WALK) |-> (wr_ptr_reg <= rd_idx_reg))
    `FC_ASSERT(a_done_idle, clk, rst_n, (state_reg == ST_DONE) |=> (state_reg == ST_IDLE))

endmodule

// File: sv/fcte_flow_mem.sv
// Flow storage: one synchronous memory, one write and one registered read port.
// Depends on fcte_pkg.
module fcte_flow_mem #(
    parameter int DEPTH = fcte_pkg::CACHE_ENTRIES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  fcte_pkg::flow_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output fcte_pkg::flow_t rd_data
);

    fcte_pkg::flow_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
